### rtl/gcl_pkg.sv
// Shared types and constants for the GCD and LCM unit.
`timescale 1ns / 1ps

package gcl_pkg;

	localparam int OPERAND_W = 32;
	localparam int LCM_W     = 64;

	typedef struct packed {
		logic [OPERAND_W-1:0] operand_a;
		logic [OPERAND_W-1:0] operand_b;
	} gcl_in_t;

	typedef struct packed {
		logic [OPERAND_W-1:0] gcd_value;
		logic [LCM_W-1:0]     lcm_value;
		logic                 both_zero_error;
	} gcl_out_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_GCD,
		B_DIV,
		B_MUL,
		B_DONE
	} gcl_state_t;

endpackage

### rtl/gcl_front.sv
// Front stage: takes items, trims the operands and marks the both-zero case.
`timescale 1ns / 1ps

module gcl_front
	import gcl_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  gcl_in_t              operands,
	output logic                 task_push,
	input  logic                 task_full,
	output logic [2*WIDTH:0]     task_data
);

	logic               valid_s1;
	logic [WIDTH-1:0]   a_s1;
	logic [WIDTH-1:0]   b_s1;
	logic               both_zero_s1;
	logic               accept;

	assign full      = valid_s1 && task_full;
	assign accept    = push && !full;
	assign task_push = valid_s1 && !task_full;
	assign task_data = {both_zero_s1, b_s1, a_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !task_push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1         <= operands.operand_a[WIDTH-1:0];
			b_s1         <= operands.operand_b[WIDTH-1:0];
			both_zero_s1 <= (operands.operand_a[WIDTH-1:0] == '0) &&
				(operands.operand_b[WIDTH-1:0] == '0);
		end
	end

endmodule

### rtl/gcl_fifo.sv
// Short queue of classified items between the front and back stages.
`timescale 1ns / 1ps

module gcl_fifo #(
	parameter int DW    = 65,
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  logic [DW-1:0] wr_data,
	output logic          q_full,
	input  logic          rd,
	output logic [DW-1:0] rd_data,
	output logic          q_empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// The fill count never exceeds the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");

	// A read alone lowers the count by one.
	a_count_read: assert property (@(posedge clk) disable iff (!arst_n)
		do_rd && !do_wr |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count not lowered on read");

	// A write alone raises the count by one.
	a_count_write: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count not raised on write");

endmodule

### rtl/gcl_core.sv
// Back stage: binary GCD loop, restoring division, multiply and result register.
`timescale 1ns / 1ps

module gcl_core
	import gcl_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  logic [2*WIDTH:0] task_data,
	output logic             take,
	output logic             empty,
	input  logic             pop,
	output gcl_out_t         result
);

	localparam int KW = $clog2(WIDTH);
	localparam int LW = 2 * WIDTH;

	gcl_state_t       state_q;
	gcl_state_t       state_d;
	logic             load_out;
	logic             out_valid_q;
	gcl_out_t         out_q;

	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [KW-1:0]    k_q;
	logic [WIDTH-1:0] g_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [KW-1:0]    cnt_q;
	logic [LW-1:0]    lcm_q;
	logic             err_q;

	logic             t_zero;
	logic [WIDTH-1:0] t_a;
	logic [WIDTH-1:0] t_b;
	logic             gcd_end;
	logic [WIDTH:0]   rem_sh;
	logic             rem_ge;

	assign t_a     = task_data[WIDTH-1:0];
	assign t_b     = task_data[2*WIDTH-1:WIDTH];
	assign t_zero  = task_data[2*WIDTH];
	assign gcd_end = (x_q == '0) || (y_q == '0);
	assign rem_sh  = {rem_q, quo_q[WIDTH-1]};
	assign rem_ge  = rem_sh >= {1'b0, g_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		take     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					take    = 1'b1;
					state_d = t_zero ? B_DONE : B_GCD;
				end
			end
			B_GCD: begin
				if (gcd_end) begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (cnt_q == '0) begin
					state_d = B_MUL;
				end
			end
			B_MUL: begin
				state_d = B_DONE;
			end
			B_DONE: begin
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (take) begin
					a_q   <= t_a;
					b_q   <= t_b;
					x_q   <= t_a;
					y_q   <= t_b;
					k_q   <= '0;
					err_q <= t_zero;
					g_q   <= '0;
					lcm_q <= '0;
				end
			end
			B_GCD: begin
				priority if (gcd_end) begin
					g_q   <= ((x_q == '0) ? y_q : x_q) << k_q;
					rem_q <= '0;
					quo_q <= a_q;
					cnt_q <= KW'(WIDTH - 1);
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= (x_q - y_q) >> 1;
				end else begin
					y_q <= (y_q - x_q) >> 1;
				end
			end
			B_DIV: begin
				rem_q <= rem_ge ? WIDTH'(rem_sh - {1'b0, g_q}) : WIDTH'(rem_sh);
				quo_q <= {quo_q[WIDTH-2:0], rem_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			B_MUL: begin
				lcm_q <= LW'(quo_q) * LW'(b_q);
			end
			B_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.gcd_value       <= OPERAND_W'(g_q);
			out_q.lcm_value       <= LCM_W'(lcm_q);
			out_q.both_zero_error <= err_q;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	// A waiting result is only dropped by a pop.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q)
		else $error("result lost without pop");

	// The divisor is never zero during the division.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> g_q != '0)
		else $error("division by zero divisor");

	// The last division step leads to the multiply.
	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV && cnt_q == '0 |=> state_q == B_MUL)
		else $error("division did not end in multiply");

endmodule

### rtl/gcd_lcm_unit.sv
// Top level of the GCD and LCM unit: front stage, queue and back stage.
//
//  Channel   Handshake          Payload
//  -------   ----------------   --------------------------------------
//  input     push / full        operands: operand_a, operand_b
//  result    empty / pop        result: gcd_value, lcm_value, both_zero_error
//
// An item with both operands zero skips the GCD loop, divider and multiplier.
// Any other item goes through the binary GCD loop, then the bit-serial divider,
// which forms operand_a divided by the GCD, and then the multiplier, which forms
// the LCM; the back stage works one item at a time.
// Reset clears all control state at once; there is no clearing pass.
// The front stage and queue keep taking items while the back stage is busy or
// a result waits to be popped, until the queue and the front register are full.
`timescale 1ns / 1ps

module gcd_lcm_unit
	import gcl_pkg::*;
#(
	parameter int WIDTH       = 32,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  gcl_in_t  operands,
	output logic     empty,
	input  logic     pop,
	output gcl_out_t result
);

	localparam int DW = 2 * WIDTH + 1;

	logic          task_push;
	logic          task_full;
	logic [DW-1:0] task_wr_data;
	logic [DW-1:0] task_rd_data;
	logic          task_empty;
	logic          task_take;

	gcl_front #(
		.WIDTH(WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.operands (operands),
		.task_push(task_push),
		.task_full(task_full),
		.task_data(task_wr_data)
	);

	gcl_fifo #(
		.DW   (DW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (task_push),
		.wr_data(task_wr_data),
		.q_full (task_full),
		.rd     (task_take),
		.rd_data(task_rd_data),
		.q_empty(task_empty)
	);

	gcl_core #(
		.WIDTH(WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (task_empty),
		.task_data(task_rd_data),
		.take     (task_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
